// ===== design/assert_macros.svh =====
// Assertion macros shared by the dynamic synapse RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define DSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the next clock edge.
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dss_pkg.sv =====
// Shared types, constants and helpers for the dynamic synapse block.
// No dependencies; used by dss_ctrl, dss_datapath and the top level.
`timescale 1ns / 1ps

package dss_pkg;

  localparam int TICK_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [28:0] LN2_Q24 = 29'd11629080;
  localparam logic [28:0] X_LIMIT = 29'd268435456;

  localparam logic [16:0] U_BASE_RST  = 17'd32768;
  localparam logic [23:0] DEPRESS_RST = 24'd1525;
  localparam logic [23:0] FACIL_RST   = 24'd33554;
  localparam logic [31:0] WEIGHT_RST  = 32'd0;
  localparam logic [16:0] DECAY_RST   = 17'd63386;

  localparam logic [3:0] TERMS = 4'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_U_BASE  = 3'd0,
    REG_DEPRESS = 3'd1,
    REG_FACIL   = 3'd2,
    REG_WEIGHT  = 3'd3,
    REG_DECAY   = 3'd4
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_ARG_MUL,
    OP_ARG_SAT,
    OP_RED,
    OP_EXP_INIT,
    OP_FT,
    OP_DIV_LD,
    OP_DIV,
    OP_T_UPD,
    OP_EXP_FIN,
    OP_M1,
    OP_A,
    OP_M2,
    OP_RW,
    OP_M3,
    OP_P,
    OP_M4,
    OP_UW,
    OP_M5,
    OP_PD,
    OP_M6,
    OP_UR,
    OP_M7,
    OP_PW,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel_f;
  } cmd_t;

  typedef struct packed {
    logic seen;
    logic spike;
    logic red_done;
    logic last_term;
    logic out_free;
  } stat_t;

  // Q16 rounding, half up.
  function automatic logic [49:0] round16(input logic [65:0] p);
    logic [65:0] s;
    s = p + 66'd32768;
    return s[65:16];
  endfunction

  function automatic logic [16:0] clamp_one(input logic [49:0] v);
    return (v > 50'(ONE_Q16)) ? ONE_Q16 : v[16:0];
  endfunction

  // Exact floor division of a 32-bit value by the series index:
  // q = (n * recip_mul(d)) >> recip_sh(d).
  function automatic logic [32:0] recip_mul(input logic [3:0] d);
    case (d)
      4'd1, 4'd2, 4'd4, 4'd8: return 33'h1_0000_0000;
      4'd3, 4'd6, 4'd12:      return 33'd5726623062;
      4'd5, 4'd10:            return 33'd6871947674;
      4'd7:                   return 33'd4908534053;
      4'd9:                   return 33'd7635497416;
      4'd11:                  return 33'd6247225158;
      default:                return 33'h1_0000_0000;
    endcase
  endfunction

  function automatic logic [5:0] recip_sh(input logic [3:0] d);
    case (d)
      4'd1:                         return 6'd32;
      4'd2:                         return 6'd33;
      4'd3, 4'd4:                   return 6'd34;
      4'd5, 4'd6, 4'd7, 4'd8:       return 6'd35;
      default:                      return 6'd36;
    endcase
  endfunction

endpackage

// ===== design/dss_ctrl.sv =====
// Sequencer for the dynamic synapse: steps the shared datapath op by op.
// Depends on dss_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dss_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  dss_pkg::stat_t stat,
  output dss_pkg::cmd_t  cmd
);
  import dss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ARG_MUL, S_ARG_SAT, S_RED, S_EXP_INIT, S_FT, S_DIV_LD, S_DIV,
    S_T_UPD, S_EXP_FIN, S_M1, S_A, S_M2, S_RW, S_M3, S_P, S_M4, S_UW,
    S_M5, S_PD, S_M6, S_UR, S_M7, S_PW, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   sel_f_r, sel_f_nxt;
  op_t    op;

  assign in_stall  = (state_r != S_IDLE);
  assign cmd.op    = op;
  assign cmd.sel_f = sel_f_r;

  always_comb begin
    state_nxt = state_r;
    sel_f_nxt = sel_f_r;
    op        = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          sel_f_nxt = 1'b0;
          state_nxt = S_M5;
        end
      end
      S_ARG_MUL:  begin op = OP_ARG_MUL;  state_nxt = S_ARG_SAT; end
      S_ARG_SAT:  begin op = OP_ARG_SAT;  state_nxt = S_RED; end
      S_RED: begin
        op = OP_RED;
        if (stat.red_done) state_nxt = S_EXP_INIT;
      end
      S_EXP_INIT: begin op = OP_EXP_INIT; state_nxt = S_FT; end
      S_FT:       begin op = OP_FT;       state_nxt = S_DIV_LD; end
      S_DIV_LD:   begin op = OP_DIV_LD;   state_nxt = S_DIV; end
      S_DIV:      begin op = OP_DIV;      state_nxt = S_T_UPD; end
      S_T_UPD: begin
        op        = OP_T_UPD;
        state_nxt = stat.last_term ? S_EXP_FIN : S_FT;
      end
      S_EXP_FIN: begin
        op = OP_EXP_FIN;
        if (!sel_f_r) begin
          sel_f_nxt = 1'b1;
          state_nxt = S_ARG_MUL;
        end else begin
          state_nxt = S_M1;
        end
      end
      S_M1: begin op = OP_M1; state_nxt = S_A; end
      S_A:  begin op = OP_A;  state_nxt = S_M2; end
      S_M2: begin op = OP_M2; state_nxt = S_RW; end
      S_RW: begin op = OP_RW; state_nxt = S_M3; end
      S_M3: begin op = OP_M3; state_nxt = S_P; end
      S_P:  begin op = OP_P;  state_nxt = S_M4; end
      S_M4: begin op = OP_M4; state_nxt = S_UW; end
      S_UW: begin op = OP_UW; state_nxt = S_M5; end
      S_M5: begin
        // recover r and u first when a spike follows an earlier one
        if (stat.spike && stat.seen && sel_f_r == 1'b0) begin
          state_nxt = S_ARG_MUL;
        end else begin
          op        = OP_M5;
          state_nxt = S_PD;
        end
      end
      S_PD: begin
        op        = OP_PD;
        state_nxt = stat.spike ? S_M6 : S_FIN;
      end
      S_M6: begin op = OP_M6; state_nxt = S_UR; end
      S_UR: begin op = OP_UR; state_nxt = S_M7; end
      S_M7: begin op = OP_M7; state_nxt = S_PW; end
      S_PW: begin op = OP_PW; state_nxt = S_FIN; end
      S_FIN: begin
        if (stat.out_free) begin
          op        = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_f_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // mark recovery done so S_M5 does not loop back
      sel_f_r <= (state_r == S_UW) ? 1'b1 : sel_f_nxt;
    end
  end

  `DSS_ASSERT_NEXT(a_fin_to_idle, state_r == S_FIN && stat.out_free, state_r == S_IDLE, "result beat not retired")

endmodule

// ===== design/dss_datapath.sv =====
// Datapath of the dynamic synapse: config registers, state, one shared
// multiplier (also used for the reciprocal division by the series index)
// and the output register. Depends on dss_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dss_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_spike_in,
  input  dss_pkg::cmd_t                    cmd,
  output dss_pkg::stat_t                   stat,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               out_psr_out
);
  import dss_pkg::*;

  logic [16:0]        u_base_r, decay_r;
  logic [23:0]        depress_r, facil_r;
  logic signed [31:0] weight_r;

  logic               seen_r, spike_r;
  logic [TICK_W-1:0]  ticks_r;
  logic [16:0]        r_r, u_r, tmp_r, er_r, eu_r;
  logic signed [31:0] psr_r;
  logic signed [33:0] acc_r;

  logic [65:0] prod_r;
  logic [28:0] x_r;
  logic [4:0]  k_r;
  logic        big_r;
  logic [31:0] f_r;
  logic [32:0] t_r;
  logic [3:0]  i_r;
  logic [31:0] dq_r;

  logic               out_valid_r;
  logic signed [31:0] out_psr_r;

  logic [32:0] mul_a, mul_b;
  logic [64:0] n_ext;
  logic        n_big;
  logic [23:0] rate;
  logic [31:0] psr_mag, w_mag;
  logic [49:0] rnd;
  logic [31:0] quo;
  logic [5:0]  sh;
  logic [39:0] exp_sum;
  logic [16:0] exp_val;
  logic [33:0] p34;
  logic signed [33:0] acc_sat_in;
  logic signed [31:0] psr_new;
  logic [17:0] u_sum;

  assign n_ext   = 65'(ticks_r);
  assign n_big   = n_ext >= 65'(X_LIMIT);
  assign rate    = cmd.sel_f ? facil_r : depress_r;
  assign psr_mag = psr_r[31] ? 32'(-psr_r) : 32'(psr_r);
  assign w_mag   = weight_r[31] ? 32'(-weight_r) : 32'(weight_r);
  assign rnd     = round16(prod_r);
  assign p34     = 34'(rnd[31:0]);
  assign quo     = 32'(prod_r >> recip_sh(i_r));
  assign sh      = 6'(k_r) + 6'd16;
  assign exp_sum = 40'(t_r) + (40'd1 << (sh - 6'd1));
  assign exp_val = big_r ? 17'd0 : 17'(exp_sum >> sh);
  assign u_sum   = 18'(u_base_r) + 18'(rnd[16:0]);
  assign acc_sat_in = acc_r;
  assign psr_new = (acc_sat_in > 34'sd2147483647)  ? 32'sh7FFF_FFFF :
                   (acc_sat_in < -34'sd2147483648) ? 32'sh8000_0000 :
                   32'(acc_sat_in);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_ARG_MUL: begin mul_a = 33'(n_ext[27:0]); mul_b = 33'(rate); end
      OP_FT:      begin mul_a = 33'(f_r);         mul_b = t_r; end
      OP_DIV:     begin mul_a = 33'(dq_r);        mul_b = recip_mul(i_r); end
      OP_M1:      begin mul_a = 33'(r_r);         mul_b = 33'(ONE_Q16 - u_r); end
      OP_M2:      begin mul_a = 33'(tmp_r);       mul_b = 33'(er_r); end
      OP_M3:      begin mul_a = 33'(u_r);         mul_b = 33'(ONE_Q16 - u_base_r); end
      OP_M4:      begin mul_a = 33'(tmp_r);       mul_b = 33'(eu_r); end
      OP_M5:      begin mul_a = 33'(psr_mag);     mul_b = 33'(decay_r); end
      OP_M6:      begin mul_a = 33'(u_r);         mul_b = 33'(r_r); end
      OP_M7:      begin mul_a = 33'(w_mag);       mul_b = 33'(tmp_r); end
      default:    begin mul_a = '0;               mul_b = '0; end
    endcase
  end

  assign stat.seen      = seen_r;
  assign stat.spike     = spike_r;
  assign stat.red_done  = x_r < LN2_Q24;
  assign stat.last_term = i_r == 4'd1;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_psr_out = out_psr_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_base_r  <= U_BASE_RST;
      depress_r <= DEPRESS_RST;
      facil_r   <= FACIL_RST;
      weight_r  <= WEIGHT_RST;
      decay_r   <= DECAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_U_BASE:  u_base_r  <= clamp_one(50'(cfg_data[16:0]));
        REG_DEPRESS: depress_r <= cfg_data[23:0];
        REG_FACIL:   facil_r   <= cfg_data[23:0];
        REG_WEIGHT:  weight_r  <= cfg_data;
        REG_DECAY:   decay_r   <= clamp_one(50'(cfg_data[16:0]));
        default: ;
      endcase
    end
  end

  // synapse state and output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      ticks_r     <= '0;
      r_r         <= ONE_Q16;
      u_r         <= U_BASE_RST;
      psr_r       <= '0;
      out_valid_r <= 1'b0;
      out_psr_r   <= '0;
    end else begin
      // hold a stalled beat, load a new one at the final step
      out_valid_r <= (cmd.op == OP_FIN) || (out_valid_r && out_stall);
      case (cmd.op)
        OP_RW: r_r <= ONE_Q16 - clamp_one(rnd);
        OP_UW: u_r <= (u_sum > 18'(ONE_Q16)) ? ONE_Q16 : u_sum[16:0];
        OP_FIN: begin
          psr_r     <= psr_new;
          out_psr_r <= psr_new;
          if (spike_r) begin
            seen_r  <= 1'b1;
            ticks_r <= TICK_W'(1);
          end else if (ticks_r != {TICK_W{1'b1}}) begin
            ticks_r <= ticks_r + TICK_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: spike_r <= in_spike_in;
      OP_ARG_SAT: begin
        k_r <= '0;
        if (rate == '0) begin
          x_r   <= '0;
          big_r <= 1'b0;
        end else if (n_big || prod_r >= 66'(X_LIMIT)) begin
          x_r   <= X_LIMIT;
          big_r <= 1'b1;
        end else begin
          x_r   <= prod_r[28:0];
          big_r <= 1'b0;
        end
      end
      OP_RED: begin
        if (x_r >= LN2_Q24) begin
          x_r <= x_r - LN2_Q24;
          k_r <= k_r + 5'd1;
        end
      end
      OP_EXP_INIT: begin
        f_r <= {x_r[23:0], 8'd0};
        t_r <= ONE_Q32;
        i_r <= TERMS;
      end
      OP_DIV_LD: dq_r <= prod_r[63:32];
      OP_T_UPD: begin
        t_r <= ONE_Q32 - 33'(quo);
        i_r <= i_r - 4'd1;
      end
      OP_EXP_FIN: begin
        if (cmd.sel_f) eu_r <= exp_val;
        else           er_r <= exp_val;
      end
      OP_A:  tmp_r <= ONE_Q16 - clamp_one(rnd);
      OP_P:  tmp_r <= rnd[16:0];
      OP_UR: tmp_r <= rnd[16:0];
      OP_PD: acc_r <= psr_r[31] ? -$signed(p34) : $signed(p34);
      OP_PW: acc_r <= acc_r + (weight_r[31] ? -$signed(p34) : $signed(p34));
      default: ;
    endcase
  end

  `DSS_ASSERT(a_ru_range, r_r <= ONE_Q16 && u_r <= ONE_Q16, "r or u above 1.0")
  `DSS_ASSERT(a_div_index, cmd.op != OP_DIV || (i_r != 4'd0 && i_r <= TERMS), "bad series index")
  `DSS_ASSERT(a_reduced, cmd.op != OP_EXP_INIT || x_r < LN2_Q24, "exp argument not reduced")

endmodule

// ===== design/dynamic_synapse_step_top.sv =====
// Top level of the dynamic synapse step block.
// Depends on dss_pkg, dss_ctrl and dss_datapath.
`timescale 1ns / 1ps
//
// Usage:
//   One input beat (in_spike_in) is one simulation tick; every tick yields
//   one output beat carrying the postsynaptic response out_psr_out (Q16.16).
//   Both channels use valid/stall; a beat moves when valid is high and stall
//   is low. Registers are written through cfg_we/cfg_index/cfg_data; the
//   user must do so only while the block is idle, as the block itself does
//   not enforce it. The work per tick grows from a tick without spike to a
//   spike with no earlier spike to a spike after an earlier one. That last
//   case is dominated by the two exponentials: each runs 12 Horner terms
//   (a product, a reciprocal multiply for the division by the term index,
//   the update) plus the ln2 range reduction.
//   One tick is in flight at a time; in_stall is high while it is worked on,
//   and the next tick is taken the cycle after the result is loaded.
//   The result sits in an output register, so a new tick is taken while a
//   finished result still waits; a stalled result holds, and the sequencer
//   waits at its final step until the output register frees up.
//   Reset (synchronous, rst_n low) restores registers and synapse state to
//   their defaults and drops any pending output beat.
//
module dynamic_synapse_step_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_spike_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             out_psr_out
);
  import dss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dss_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_spike_in (in_spike_in),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_psr_out (out_psr_out)
  );

endmodule
